// File: src/nmsc_pkg.sv
// ----------------------------------------------------------------------------
// nmsc_pkg
// Shared types, character codes and helpers for the sentence checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nmsc_pkg;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW    = 8'd32;
  localparam logic [7:0] CH_HIGH   = 8'd126;

  localparam logic [7:0]  MIN_LINE = 8'd9;
  localparam logic [23:0] TAIL_RMC = 24'h524D43;
  localparam logic [23:0] TAIL_GGA = 24'h474741;

  // comma counts needed before a type is recognized
  localparam logic [3:0] RMC_COMMAS = 4'd9;
  localparam logic [3:0] GGA_COMMAS = 4'd7;

  // the three fields that matter
  localparam logic [3:0] FLD_TYPE   = 4'd0;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_SATS   = 4'd7;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_NO_STAR  = 3'd2,
    ST_BAD_HEX  = 3'd3,
    ST_MISMATCH = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_RMC   = 2'd1,
    KIND_GGA   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SF_EMPTY = 2'd0,
    SF_IS_A  = 2'd1,
    SF_OTHER = 2'd2
  } stat_fld_e;

  typedef struct packed {
    status_e     status;
    kind_e       kind;
    logic        fix;
    logic [7:0]  sats;
  } result_t;

  // bit 4 set when the character is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = {1'b0, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = {1'b0, 4'(b - 8'h57)};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/nmsc_line_parser.sv
// ----------------------------------------------------------------------------
// nmsc_line_parser
// Per-byte line state update and end-of-line judgement, one byte per cycle while step_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module nmsc_line_parser #(
  parameter int MAX_LINE = 128
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  output logic                  emit_o,
  output nmsc_pkg::result_t     res_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_LINE);

  logic [7:0]          len_q, len_d;
  logic                dollar_q, dollar_d;
  logic [7:0]          parity_q, parity_d;
  logic                star_q, star_d;
  logic [1:0]          after_q, after_d;
  logic [7:0]          cks_q, cks_d;
  logic                hexbad_q, hexbad_d;
  logic [3:0]          comma_q, comma_d;
  logic [23:0]         tail_q, tail_d;
  logic [1:0]          tlen_q, tlen_d;
  nmsc_pkg::stat_fld_e sf_q, sf_d;
  logic [7:0]          cf_val_q, cf_val_d;
  logic                cf_ne_q, cf_ne_d;
  logic                cf_end_q, cf_end_d;
  logic                fix_q, fix_d;
  logic [7:0]          sats_q, sats_d;

  logic                is_eol;
  logic                is_print;
  logic                is_digit;
  logic                line_clr;
  logic [4:0]          hex_v;
  logic [11:0]         cf_next;
  nmsc_pkg::status_e   status;
  nmsc_pkg::kind_e     kind;

  assign is_eol   = (byte_i == nmsc_pkg::CH_CR) || (byte_i == nmsc_pkg::CH_LF);
  assign is_print = (byte_i >= nmsc_pkg::CH_LOW) && (byte_i <= nmsc_pkg::CH_HIGH);
  assign is_digit = (byte_i >= nmsc_pkg::CH_ZERO) && (byte_i <= nmsc_pkg::CH_NINE);
  assign hex_v    = nmsc_pkg::hex_value(byte_i);
  assign cf_next  = 12'(cf_val_q) * 12'd10 + 12'(byte_i[3:0]);

  // verdict on the line held so far
  always_comb begin
    if (len_q < nmsc_pkg::MIN_LINE || !dollar_q) begin
      status = nmsc_pkg::ST_SHORT;
    end else if (!star_q || after_q < 2'd2) begin
      status = nmsc_pkg::ST_NO_STAR;
    end else if (hexbad_q) begin
      status = nmsc_pkg::ST_BAD_HEX;
    end else if (parity_q != cks_q) begin
      status = nmsc_pkg::ST_MISMATCH;
    end else begin
      status = nmsc_pkg::ST_OK;
    end
  end

  always_comb begin
    len_d    = len_q;
    dollar_d = dollar_q;
    parity_d = parity_q;
    star_d   = star_q;
    after_d  = after_q;
    cks_d    = cks_q;
    hexbad_d = hexbad_q;
    comma_d  = comma_q;
    tail_d   = tail_q;
    tlen_d   = tlen_q;
    sf_d     = sf_q;
    cf_val_d = cf_val_q;
    cf_ne_d  = cf_ne_q;
    cf_end_d = cf_end_q;
    fix_d    = fix_q;
    sats_d   = sats_q;
    emit_o   = 1'b0;
    line_clr = 1'b0;
    kind     = nmsc_pkg::KIND_OTHER;

    if (is_eol) begin
      if (len_q != 8'd0) begin
        emit_o   = 1'b1;
        line_clr = 1'b1;
        if (status == nmsc_pkg::ST_OK && tlen_q == 2'd3) begin
          if (tail_q == nmsc_pkg::TAIL_RMC && comma_q >= nmsc_pkg::RMC_COMMAS) begin
            kind  = nmsc_pkg::KIND_RMC;
            fix_d = (sf_q == nmsc_pkg::SF_IS_A);
          end else if (tail_q == nmsc_pkg::TAIL_GGA &&
                       comma_q >= nmsc_pkg::GGA_COMMAS) begin
            kind = nmsc_pkg::KIND_GGA;
            if (cf_ne_q) begin
              sats_d = cf_val_q;
            end
          end
        end
      end
    end else if (is_print) begin
      if (len_q >= MaxLen) begin
        // overlong line is thrown away along with this byte
        line_clr = 1'b1;
      end else begin
        len_d = len_q + 8'd1;
        if (len_q == 8'd0) begin
          dollar_d = (byte_i == nmsc_pkg::CH_DOLLAR);
        end else if (!star_q) begin
          if (byte_i == nmsc_pkg::CH_STAR) begin
            star_d = 1'b1;
          end else begin
            parity_d = parity_q ^ byte_i;
            if (byte_i == nmsc_pkg::CH_COMMA) begin
              if (comma_q != 4'hF) begin
                comma_d = comma_q + 4'd1;
              end
            end else if (comma_q == nmsc_pkg::FLD_TYPE) begin
              tail_d = {tail_q[15:0], byte_i};
              if (tlen_q != 2'd3) begin
                tlen_d = tlen_q + 2'd1;
              end
            end else if (comma_q == nmsc_pkg::FLD_STATUS) begin
              sf_d = (sf_q == nmsc_pkg::SF_EMPTY && byte_i == nmsc_pkg::CH_A) ?
                     nmsc_pkg::SF_IS_A : nmsc_pkg::SF_OTHER;
            end else if (comma_q == nmsc_pkg::FLD_SATS) begin
              cf_ne_d = 1'b1;
              if (!cf_end_q && is_digit) begin
                cf_val_d = (cf_next > 12'd255) ? 8'hFF : cf_next[7:0];
              end else begin
                cf_end_d = 1'b1;
              end
            end
          end
        end else if (after_q < 2'd2) begin
          if (hex_v[4]) begin
            hexbad_d = 1'b1;
          end else begin
            cks_d = {cks_q[3:0], hex_v[3:0]};
          end
          after_d = after_q + 2'd1;
        end
      end
    end

    if (line_clr) begin
      len_d    = '0;
      dollar_d = 1'b0;
      parity_d = '0;
      star_d   = 1'b0;
      after_d  = '0;
      cks_d    = '0;
      hexbad_d = 1'b0;
      comma_d  = '0;
      tail_d   = '0;
      tlen_d   = '0;
      sf_d     = nmsc_pkg::SF_EMPTY;
      cf_val_d = '0;
      cf_ne_d  = 1'b0;
      cf_end_d = 1'b0;
    end
  end

  assign res_o.status = status;
  assign res_o.kind   = kind;
  assign res_o.fix    = fix_d;
  assign res_o.sats   = sats_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      dollar_q <= 1'b0;
      parity_q <= '0;
      star_q   <= 1'b0;
      after_q  <= '0;
      cks_q    <= '0;
      hexbad_q <= 1'b0;
      comma_q  <= '0;
      tail_q   <= '0;
      tlen_q   <= '0;
      sf_q     <= nmsc_pkg::SF_EMPTY;
      cf_val_q <= '0;
      cf_ne_q  <= 1'b0;
      cf_end_q <= 1'b0;
      fix_q    <= 1'b0;
      sats_q   <= '0;
    end else if (step_i) begin
      len_q    <= len_d;
      dollar_q <= dollar_d;
      parity_q <= parity_d;
      star_q   <= star_d;
      after_q  <= after_d;
      cks_q    <= cks_d;
      hexbad_q <= hexbad_d;
      comma_q  <= comma_d;
      tail_q   <= tail_d;
      tlen_q   <= tlen_d;
      sf_q     <= sf_d;
      cf_val_q <= cf_val_d;
      cf_ne_q  <= cf_ne_d;
      cf_end_q <= cf_end_d;
      fix_q    <= fix_d;
      sats_q   <= sats_d;
    end
  end

endmodule

`default_nettype wire

// File: src/nmsc_out_stage.sv
// ----------------------------------------------------------------------------
// nmsc_out_stage
// Result register toward the consumer, valid/stall handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module nmsc_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire nmsc_pkg::result_t res_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output nmsc_pkg::result_t      res_o
);

  logic              valid_q, valid_d;
  nmsc_pkg::result_t res_q;

  // slot can take a word when empty or when its word leaves this cycle
  assign free_o  = !valid_q || !stall_i;
  assign valid_d = load_i || (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// File: src/nmea_sentence_checker.sv
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// Streams NMEA 0183 bytes and reports one checked result per ended line.
// ----------------------------------------------------------------------------
// One byte is taken per clock while the input is not stalled. A byte lands in
// an input register, then the line parser folds it into the running line state
// and, on CR or LF ending a non-empty line, loads one result word into the
// output register, so a line's result passes the input register and then the
// output register before it is presented. Throughput is one byte per cycle;
// the input stalls only while the held byte ends a line and the output register
// still holds a word that is being stalled. Results carry the line status, the
// recognized sentence kind and the fix flag and satellite count as they stand
// after that line.
`default_nettype none

module nmea_sentence_checker #(
  parameter int MAX_LINE = 128
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      line_status_o,
  output logic [1:0]      sentence_kind_o,
  output logic            fix_valid_o,
  output logic [7:0]      satellites_o
);

  logic              byte_valid_q, byte_valid_d;
  logic [7:0]        byte_q;
  logic              emit;
  logic              out_free;
  logic              advance;
  logic              in_take;
  nmsc_pkg::result_t res;
  nmsc_pkg::result_t res_out;

  // held byte moves on unless it makes a word and the output slot is full
  assign advance      = byte_valid_q && (!emit || out_free);
  assign in_stall_o   = byte_valid_q && !advance;
  assign in_take      = in_valid_i && !in_stall_o;
  assign byte_valid_d = in_take || (byte_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else begin
      byte_valid_q <= byte_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= rx_byte_i;
    end
  end

  nmsc_line_parser #(
    .MAX_LINE(MAX_LINE)
  ) u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .byte_i(byte_q),
    .emit_o(emit),
    .res_o (res)
  );

  nmsc_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance && emit),
    .res_i  (res),
    .free_o (out_free),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .res_o  (res_out)
  );

  assign line_status_o   = res_out.status;
  assign sentence_kind_o = res_out.kind;
  assign fix_valid_o     = res_out.fix;
  assign satellites_o    = res_out.sats;

endmodule

`default_nettype wire

// File: src/nmsc_checker.sv
// ----------------------------------------------------------------------------
// nmsc_checker
// Port-level checks on the result stream of the sentence checker.
// ----------------------------------------------------------------------------
`default_nettype none

module nmsc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] rx_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [2:0] line_status_o,
  input wire logic [1:0] sentence_kind_o,
  input wire logic       fix_valid_o,
  input wire logic [7:0] satellites_o
);

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(rx_byte_i))
    else $error("input word changed while stalled");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_status_o) &&
      $stable(sentence_kind_o) && $stable(fix_valid_o) && $stable(satellites_o))
    else $error("result word changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_status_o <= nmsc_pkg::ST_MISMATCH)
    else $error("line status out of range");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sentence_kind_o <= nmsc_pkg::KIND_GGA)
    else $error("sentence kind out of range");

  // only a clean line can be recognized
  a_kind_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sentence_kind_o != nmsc_pkg::KIND_OTHER |->
      line_status_o == nmsc_pkg::ST_OK)
    else $error("sentence recognized on a failed line");

endmodule

bind nmea_sentence_checker nmsc_checker u_nmsc_checker (.*);

`default_nettype wire

// File: verif/nmea_sentence_checker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nmea_sentence_checker_test
// Feeds framed NMEA sentences, broken lines and raw noise into the checker and
// compares every line report with a cycle-free model of the line parser, under
// phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module nmea_sentence_checker_test;

  localparam int LINE_LIMIT      = 128;
  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 11;
  localparam int PHASE_ITEMS     = 200;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int SETTLE_CYCLES   = 10;

  localparam logic [7:0] CH_F       = "F";
  localparam logic [7:0] CH_Z       = "Z";
  localparam logic [7:0] CH_SMALL_A = "a";
  localparam logic [7:0] CH_SMALL_F = "f";

  // how a sentence body gets framed on the wire
  typedef enum int {
    FR_GOOD,
    FR_LOWER,
    FR_TRAILING,
    FR_BAD_SUM,
    FR_BAD_HEX,
    FR_ONE_DIGIT,
    FR_NO_STAR,
    FR_NO_DOLLAR
  } frame_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] line_status_o;
  logic [1:0] sentence_kind_o;
  logic       fix_valid_o;
  logic [7:0] satellites_o;

  logic [7:0]        pending_bytes[$];
  logic [7:0]        sentence_buf[$];
  nmsc_pkg::result_t line_reports[$];

  int   send_gap_pct;
  int   recv_stall_pct;
  int   bytes_queued;
  int   mismatch_count;
  int   stuck_cycles;
  logic byte_taken;

  // parser model state
  logic [7:0]          line_len;
  logic                dollar_first;
  logic [7:0]          xor_sum;
  logic                star_seen;
  logic [1:0]          after_star;
  logic [7:0]          sum_field;
  logic                bad_hex;
  logic [3:0]          commas;
  logic [23:0]         type_tail;
  logic [1:0]          type_len;
  nmsc_pkg::stat_fld_e status_fld;
  logic [7:0]          sats_acc;
  logic                sats_present;
  logic                sats_stopped;
  logic                fix_now;
  logic [7:0]          sats_now;

  nmea_sentence_checker #(
    .MAX_LINE(LINE_LIMIT)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_status_o  (line_status_o),
    .sentence_kind_o(sentence_kind_o),
    .fix_valid_o    (fix_valid_o),
    .satellites_o   (satellites_o)
  );

  always begin
    clk_i = 1'b0;
    #HALF_PERIOD;
    clk_i = 1'b1;
    #HALF_PERIOD;
  end

  task automatic start_new_line();
    line_len     = '0;
    dollar_first = 1'b0;
    xor_sum      = '0;
    star_seen    = 1'b0;
    after_star   = '0;
    sum_field    = '0;
    bad_hex      = 1'b0;
    commas       = '0;
    type_tail    = '0;
    type_len     = '0;
    status_fld   = nmsc_pkg::SF_EMPTY;
    sats_acc     = '0;
    sats_present = 1'b0;
    sats_stopped = 1'b0;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    nmsc_pkg::result_t r;
    logic [3:0]        nib;
    logic              hex_ok;
    int                v;
    if (b == nmsc_pkg::CH_CR || b == nmsc_pkg::CH_LF) begin
      if (line_len != 0) begin
        r.kind = nmsc_pkg::KIND_OTHER;
        if (line_len < nmsc_pkg::MIN_LINE || !dollar_first) begin
          r.status = nmsc_pkg::ST_SHORT;
        end else if (!star_seen || after_star < 2'd2) begin
          r.status = nmsc_pkg::ST_NO_STAR;
        end else if (bad_hex) begin
          r.status = nmsc_pkg::ST_BAD_HEX;
        end else if (xor_sum != sum_field) begin
          r.status = nmsc_pkg::ST_MISMATCH;
        end else begin
          r.status = nmsc_pkg::ST_OK;
        end
        if (r.status == nmsc_pkg::ST_OK && type_len == 2'd3) begin
          if (type_tail == nmsc_pkg::TAIL_RMC && commas >= nmsc_pkg::RMC_COMMAS) begin
            r.kind  = nmsc_pkg::KIND_RMC;
            fix_now = (status_fld == nmsc_pkg::SF_IS_A);
          end else if (type_tail == nmsc_pkg::TAIL_GGA &&
                       commas >= nmsc_pkg::GGA_COMMAS) begin
            r.kind = nmsc_pkg::KIND_GGA;
            if (sats_present) begin
              sats_now = sats_acc;
            end
          end
        end
        r.fix  = fix_now;
        r.sats = sats_now;
        line_reports.insert(line_reports.size(), r);
        start_new_line();
      end
    end else if (b >= nmsc_pkg::CH_LOW && b <= nmsc_pkg::CH_HIGH) begin
      if (line_len >= LINE_LIMIT) begin
        // line too long: drop it along with this byte
        start_new_line();
      end else begin
        line_len = line_len + 8'd1;
        if (line_len == 8'd1) begin
          dollar_first = (b == nmsc_pkg::CH_DOLLAR);
        end else if (!star_seen) begin
          if (b == nmsc_pkg::CH_STAR) begin
            star_seen = 1'b1;
          end else begin
            xor_sum = xor_sum ^ b;
            if (b == nmsc_pkg::CH_COMMA) begin
              if (commas != 4'd15) begin
                commas = commas + 4'd1;
              end
            end else if (commas == nmsc_pkg::FLD_TYPE) begin
              type_tail = {type_tail[15:0], b};
              if (type_len != 2'd3) begin
                type_len = type_len + 2'd1;
              end
            end else if (commas == nmsc_pkg::FLD_STATUS) begin
              status_fld = (status_fld == nmsc_pkg::SF_EMPTY && b == nmsc_pkg::CH_A) ?
                           nmsc_pkg::SF_IS_A : nmsc_pkg::SF_OTHER;
            end else if (commas == nmsc_pkg::FLD_SATS) begin
              sats_present = 1'b1;
              if (!sats_stopped && b >= nmsc_pkg::CH_ZERO && b <= nmsc_pkg::CH_NINE) begin
                v        = int'(sats_acc) * 10 + int'(b - nmsc_pkg::CH_ZERO);
                sats_acc = (v > 255) ? 8'd255 : 8'(v);
              end else begin
                sats_stopped = 1'b1;
              end
            end
          end
        end else if (after_star < 2'd2) begin
          hex_ok = 1'b1;
          nib    = '0;
          if (b >= nmsc_pkg::CH_ZERO && b <= nmsc_pkg::CH_NINE) begin
            nib = 4'(b - nmsc_pkg::CH_ZERO);
          end else if (b >= nmsc_pkg::CH_A && b <= CH_F) begin
            nib = 4'(b - nmsc_pkg::CH_A + 8'd10);
          end else if (b >= CH_SMALL_A && b <= CH_SMALL_F) begin
            nib = 4'(b - CH_SMALL_A + 8'd10);
          end else begin
            hex_ok = 1'b0;
          end
          if (hex_ok) begin
            sum_field = {sum_field[3:0], nib};
          end else begin
            bad_hex = 1'b1;
          end
          after_star = after_star + 2'd1;
        end
      end
    end
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns %s mismatch: expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // ---- stimulus helpers ----

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.insert(pending_bytes.size(), b);
    if ((b >= nmsc_pkg::CH_LOW && b <= nmsc_pkg::CH_HIGH) ||
        b == nmsc_pkg::CH_CR || b == nmsc_pkg::CH_LF) begin
      bytes_queued++;
    end
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_byte(s[i]);
    end
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      sentence_buf.insert(sentence_buf.size(), s[i]);
    end
  endtask

  task automatic put_rand_field(input int max_len);
    logic [7:0] c;
    repeat ($urandom_range(max_len)) begin
      do begin
        c = 8'($urandom_range(nmsc_pkg::CH_HIGH, nmsc_pkg::CH_LOW));
      end while (c == nmsc_pkg::CH_COMMA || c == nmsc_pkg::CH_STAR);
      sentence_buf.insert(sentence_buf.size(), c);
    end
  endtask

  task automatic put_digit();
    sentence_buf.insert(sentence_buf.size(), nmsc_pkg::CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic end_line();
    case ($urandom_range(3))
      0: queue_byte(nmsc_pkg::CH_CR);
      1: queue_byte(nmsc_pkg::CH_LF);
      2: begin
        queue_byte(nmsc_pkg::CH_CR);
        queue_byte(nmsc_pkg::CH_LF);
      end
      default: begin
        queue_byte(nmsc_pkg::CH_LF);
        queue_byte(nmsc_pkg::CH_CR);
      end
    endcase
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) begin
      return nmsc_pkg::CH_ZERO + 8'(n);
    end
    return (lower ? CH_SMALL_A : nmsc_pkg::CH_A) + 8'(n) - 8'd10;
  endfunction

  // frames the body with dollar, star and checksum as the framing mode asks, then sends it with junk mixed in
  task automatic ship_line(input frame_e mode, input int junk_pct);
    logic [7:0] sum;
    logic [7:0] digits[2];
    logic [7:0] junk;
    string      non_hex;
    non_hex = "GgZz*$ ,.~";
    sum = '0;
    foreach (sentence_buf[i]) begin
      sum = sum ^ sentence_buf[i];
    end
    if (mode == FR_BAD_SUM) begin
      sum = sum ^ 8'($urandom_range(255, 1));
    end
    digits[0] = hex_char(sum[7:4], mode == FR_LOWER);
    digits[1] = hex_char(sum[3:0], mode == FR_LOWER);
    if (mode == FR_BAD_HEX) begin
      digits[$urandom_range(1)] = non_hex[$urandom_range(non_hex.len() - 1)];
    end
    if (mode != FR_NO_DOLLAR) begin
      sentence_buf.push_front(nmsc_pkg::CH_DOLLAR);
    end
    if (mode != FR_NO_STAR) begin
      sentence_buf.insert(sentence_buf.size(), nmsc_pkg::CH_STAR);
      sentence_buf.insert(sentence_buf.size(), digits[0]);
      if (mode != FR_ONE_DIGIT) begin
        sentence_buf.insert(sentence_buf.size(), digits[1]);
      end
    end
    if (mode == FR_TRAILING) begin
      put_rand_field(6);
    end
    foreach (sentence_buf[i]) begin
      if ($urandom_range(99) < junk_pct) begin
        do begin
          junk = 8'($urandom);
        end while ((junk >= nmsc_pkg::CH_LOW && junk <= nmsc_pkg::CH_HIGH) ||
                   junk == nmsc_pkg::CH_CR || junk == nmsc_pkg::CH_LF);
        queue_byte(junk);
      end
      queue_byte(sentence_buf[i]);
    end
    sentence_buf.delete();
    end_line();
  endtask

  task automatic send_long_line(input int n);
    queue_byte(nmsc_pkg::CH_DOLLAR);
    repeat (n - 1) begin
      queue_byte(8'($urandom_range(nmsc_pkg::CH_HIGH, nmsc_pkg::CH_LOW)));
    end
    end_line();
  endtask

  // RMC, GGA or some other type, with random field content
  task automatic random_body();
    int pick;
    int fields;
    pick = $urandom_range(2);
    case ($urandom_range(4))
      0: put_text("GP");
      1: put_text("GN");
      2: put_text("GL");
      3: put_text("XYZ");
      default: ;
    endcase
    if (pick == 0) begin
      put_text("RMC");
    end else if (pick == 1) begin
      put_text("GGA");
    end else begin
      repeat ($urandom_range(4)) begin
        sentence_buf.insert(sentence_buf.size(), 8'($urandom_range(CH_Z, nmsc_pkg::CH_A)));
      end
    end
    fields = (pick == 2) ? $urandom_range(18) : $urandom_range(12, 6);
    for (int f = 1; f <= fields; f++) begin
      sentence_buf.insert(sentence_buf.size(), nmsc_pkg::CH_COMMA);
      if (pick == 0 && f == nmsc_pkg::FLD_STATUS) begin
        case ($urandom_range(5))
          0, 1: put_text("A");
          2: put_text("V");
          3: ;
          4: put_text("AA");
          default: put_rand_field(2);
        endcase
      end else if (pick == 1 && f == nmsc_pkg::FLD_SATS) begin
        case ($urandom_range(5))
          0, 1: repeat ($urandom_range(2, 1)) put_digit();
          2: repeat ($urandom_range(5, 3)) put_digit();
          3: ;
          4: put_rand_field(3);
          default: begin
            put_digit();
            put_rand_field(3);
          end
        endcase
      end else begin
        put_rand_field(4);
      end
    end
  endtask

  task automatic directed_lines();
    // unprintable extremes between lines are dropped
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h1F);
    queue_byte(8'h7F);
    queue_byte(8'h80);
    put_text("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394");
    ship_line(FR_GOOD, 0);
    put_text("GNRMC,1,V,2,N,3,E,4,5,6,,A");
    ship_line(FR_LOWER, 0);
    // comma count saturates, junk inside the sentence
    put_text("GPRMC,,A,,,,,,,,,,,,,,,,,,");
    ship_line(FR_GOOD, 30);
    put_text("GPRMC,1,AA,2,N,3,E,4,5,6");
    ship_line(FR_TRAILING, 0);
    put_text("GPRMC,1,A,2,N,3,E,4,5");
    ship_line(FR_GOOD, 0);
    put_text("GPGGA,1,2,N,3,E,1,08,0.9");
    ship_line(FR_GOOD, 0);
    put_text("GPGGA,1,2,N,3,E,1,300");
    ship_line(FR_GOOD, 0);
    put_text("GPGGA,1,2,N,3,E,1,,5");
    ship_line(FR_GOOD, 0);
    put_text("GPGGA,1,2,N,3,E,1,x7");
    ship_line(FR_GOOD, 0);
    put_text("GPGGA,1,2,N,3,E,1,12a");
    ship_line(FR_GOOD, 0);
    put_text("GPGGA,1,2,N,3,E,1");
    ship_line(FR_GOOD, 0);
    put_text("GA,1,2,3,4,5,6,7,8");
    ship_line(FR_GOOD, 0);
    put_text("GPGGA,1,2,N,3,E,1,05");
    ship_line(FR_BAD_SUM, 0);
    put_text("GPRMC,1,A,2,N,3,E,4,5,6");
    ship_line(FR_BAD_HEX, 0);
    put_text("GPRMC,1,A,2,N,3,E,4,5,6");
    ship_line(FR_ONE_DIGIT, 0);
    put_text("GPRMC,1,A,2,N,3,E,4,5,6");
    ship_line(FR_NO_STAR, 0);
    put_text("GPRMC,1,A,2,N,3,E,4,5,6");
    ship_line(FR_NO_DOLLAR, 0);
    put_text("A");
    ship_line(FR_GOOD, 0);
    push_text("*GPGGA,1,2*00");
    end_line();
    // star right after the dollar, printable extremes past the checksum
    push_text("$*00 ~~~~~");
    end_line();
    end_line();
    send_long_line(LINE_LIMIT);
    send_long_line(LINE_LIMIT + 1);
    send_long_line(LINE_LIMIT + 2);
  endtask

  task automatic random_lines(input int goal);
    int first;
    int pick;
    first = bytes_queued;
    while (bytes_queued - first < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        random_body();
        ship_line(frame_e'($urandom_range(FR_TRAILING)), ($urandom_range(9) == 0) ? 10 : 0);
      end else if (pick < 85) begin
        random_body();
        ship_line(frame_e'($urandom_range(FR_NO_DOLLAR, FR_BAD_SUM)), 0);
      end else if (pick < 90) begin
        if ($urandom_range(1) == 1) begin
          queue_byte(nmsc_pkg::CH_DOLLAR);
        end
        repeat ($urandom_range(8, 1)) begin
          queue_byte(8'($urandom_range(nmsc_pkg::CH_HIGH, nmsc_pkg::CH_LOW)));
        end
        end_line();
      end else if (pick < 94) begin
        send_long_line($urandom_range(260, 100));
      end else begin
        repeat ($urandom_range(8, 1)) begin
          queue_byte(8'($urandom));
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid_i || line_reports.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // ---- driver ----

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    // hold the word until it is taken
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        rx_byte_i  <= pending_bytes.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---- monitor ----

  always @(posedge clk_i) begin : monitor
    nmsc_pkg::result_t want;
    if (!rst_ni) begin
      byte_taken   <= 1'b0;
      stuck_cycles = 0;
    end else begin
      byte_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        if (line_reports.size() == 0) begin
          $display("%0t ns unexpected word: expected none, got status %0d kind %0d %s",
                   $time, line_status_o, sentence_kind_o,
                   $sformatf("fix %0d sats %0d", fix_valid_o, satellites_o));
          mismatch_count++;
        end else begin
          want = line_reports.pop_front();
          check_field("line_status", want.status, line_status_o);
          check_field("sentence_kind", want.kind, sentence_kind_o);
          check_field("fix_valid", want.fix, fix_valid_o);
          check_field("satellites", want.sats, satellites_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        parse_rx_byte(rx_byte_i);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
  end

  initial begin : watchdog
    while (stuck_cycles < WATCHDOG_CYCLES) begin
      @(negedge clk_i);
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    rx_byte_i      = '0;
    out_stall_i    = 1'b0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    bytes_queued   = 0;
    mismatch_count = 0;
    stuck_cycles   = 0;
    fix_now        = 1'b0;
    sats_now       = '0;
    start_new_line();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    directed_lines();
    random_lines(PHASE_ITEMS);
    wait_drained();

    send_gap_pct = 51;
    random_lines(PHASE_ITEMS);
    wait_drained();

    send_gap_pct   = 0;
    recv_stall_pct = 51;
    random_lines(PHASE_ITEMS);
    wait_drained();

    send_gap_pct   = 18;
    recv_stall_pct = 18;
    random_lines(PHASE_ITEMS);
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
